// ===== hdl/ffha_pkg.sv =====
// ============================================================================
// First-fit heap allocator package
// Shared sizes, status codes, request codes and register indices for the allocator.
// ============================================================================
`default_nettype none

package ffha_pkg;

    localparam int MAX_BLOCKS  = 64;
    localparam int ALIGN_BYTES = 256;
    localparam int IDX_W       = $clog2(MAX_BLOCKS);
    localparam int CNT_W       = $clog2(MAX_BLOCKS + 1);
    localparam int ALIGN_W     = $clog2(ALIGN_BYTES);
    localparam int OFF_W       = 40;
    localparam int SIZE_W      = 41;
    localparam int ADDR_W      = 49;
    localparam int BASE_W      = 48;
    localparam int ENTRY_W     = OFF_W + SIZE_W + 1;

    localparam logic [SIZE_W-1:0] HEAP_LIMIT  = SIZE_W'(64'd1 << 40);
    localparam logic [SIZE_W-1:0] HEAP_RESET  = SIZE_W'(64'd17179869184);

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOFIT    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_OUTSIDE  = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_ZERO     = 3'd5;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_BYTES = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/ffha_ram.sv =====
// ============================================================================
// Generic RAM
// Single write port, single read port with a registered read.
// ============================================================================
`default_nettype none

module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/first_fit_heap_allocator.sv =====
// ============================================================================
// First-fit heap allocator
// Ordered block table with first-fit allocation, splitting and coalescing.
// ============================================================================
// A scan reads one entry per cycle and each table shift moves one entry per
// cycle. Throughput: one request at a time; the next is accepted once the
// result is registered, and a result that waits on m_ready holds the sequencer
// in its last state. Reset (synchronous, active low) restores the default
// registers. The first cycle after reset, or after a register write, stores
// one free block that covers the heap.
`default_nettype none

module first_fit_heap_allocator (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // Request channel.
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_req_type,
    input  wire logic [ffha_pkg::SIZE_W-1:0] s_alloc_bytes,
    input  wire logic [ffha_pkg::ADDR_W-1:0] s_free_address,
    // Result channel.
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic      [2:0]                  m_status,
    output logic      [ffha_pkg::ADDR_W-1:0] m_address,
    // Configuration write channel.
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic                        cfg_index,
    input  wire logic [ffha_pkg::BASE_W-1:0] cfg_data
);

    import ffha_pkg::*;

    // Sequencer states.
    localparam logic [3:0] S_INIT    = 4'd0;  // write the single free block
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_CHECK   = 4'd2;  // early status checks
    localparam logic [3:0] S_EVAL    = 4'd3;  // look at entry idx
    localparam logic [3:0] S_SHW     = 4'd4;  // insert shift: entry j-1 to j
    localparam logic [3:0] S_SPLIT   = 4'd5;  // write the free remainder
    localparam logic [3:0] S_SETUSED = 4'd6;  // write the used piece
    localparam logic [3:0] S_NXEV    = 4'd7;  // free: look at next neighbour
    localparam logic [3:0] S_PVEV    = 4'd8;  // free: look at previous neighbour
    localparam logic [3:0] S_ERW     = 4'd9;  // erase shift: entry j+1 to j
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0]           state_reg, state_next;
    logic [BASE_W-1:0]    base_reg;
    logic [SIZE_W-1:0]    bytes_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 rtype_reg;
    logic [SIZE_W:0]      want_reg;
    logic [ADDR_W-1:0]    faddr_reg;
    logic [OFF_W-1:0]     foff_reg;
    logic [CNT_W-1:0]     idx_reg, idx_next;     // entry under work
    logic [CNT_W-1:0]     j_reg, j_next;         // shift cursor
    logic [OFF_W-1:0]     cur_off_reg, cur_off_next;
    logic [SIZE_W-1:0]    cur_size_reg, cur_size_next;
    logic                 pend_prev_reg, pend_prev_next;
    logic [2:0]           st_reg, st_next;
    logic [ADDR_W-1:0]    ad_reg, ad_next;
    logic [2:0]           out_status_reg;
    logic [ADDR_W-1:0]    out_addr_reg;
    logic                 mvalid_reg;
    logic                 load_out;

    // Table memory: {offset, size, used} per entry.
    logic                 we;
    logic [IDX_W-1:0]     waddr, raddr;
    logic [ENTRY_W-1:0]   wdata, rdata;

    ffha_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_table (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    logic [OFF_W-1:0]  rd_off;
    logic [SIZE_W-1:0] rd_size;
    logic              rd_used;
    assign rd_off  = rdata[ENTRY_W-1 -: OFF_W];
    assign rd_size = rdata[SIZE_W:1];
    assign rd_used = rdata[0];

    // Requested size rounded up to the alignment. One extra bit keeps a size
    // near the top of the field from wrapping to zero.
    logic [SIZE_W:0]   want_calc;
    assign want_calc = ({1'b0, s_alloc_bytes} + (SIZE_W+1)'(ALIGN_BYTES - 1))
                       & ~(SIZE_W+1)'(ALIGN_BYTES - 1);

    // A request is held off while a register write is offered, so the two
    // never land in the same cycle. Register writes wait for an empty result.
    logic              cfg_fire;
    logic              s_fire;
    assign s_ready   = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE) && !mvalid_reg;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_fire    = s_valid && s_ready;

    logic [ADDR_W-1:0] heap_end;
    assign heap_end = ADDR_W'(base_reg) + ADDR_W'(bytes_reg);

    logic [CNT_W-1:0]  idx_inc, idx_inc2, idx_dec, j_dec, j_dec2, j_inc, j_inc2;
    logic [CNT_W-1:0]  count_inc, count_dec;
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign idx_inc2  = idx_reg + CNT_W'(2);
    assign idx_dec   = idx_reg - CNT_W'(1);
    assign j_dec     = j_reg - CNT_W'(1);
    assign j_dec2    = j_reg - CNT_W'(2);
    assign j_inc     = j_reg + CNT_W'(1);
    assign j_inc2    = j_reg + CNT_W'(2);
    assign count_inc = count_reg + CNT_W'(1);
    assign count_dec = count_reg - CNT_W'(1);

    // Size of the freed block plus the neighbour that is read this cycle.
    logic [SIZE_W-1:0] sum_size;
    assign sum_size = cur_size_reg + rd_size;

    // The table memory has a registered read, so an address presented in one
    // state is looked at in the next.
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        j_next         = j_reg;
        cur_off_next   = cur_off_reg;
        cur_size_next  = cur_size_reg;
        pend_prev_next = pend_prev_reg;
        st_next        = st_reg;
        ad_next        = ad_reg;
        load_out       = 1'b0;
        we             = 1'b0;
        waddr          = idx_reg[IDX_W-1:0];
        wdata          = {cur_off_reg, cur_size_reg, 1'b0};
        raddr          = idx_reg[IDX_W-1:0];
        unique case (state_reg)
            S_INIT: begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = {{OFF_W{1'b0}}, bytes_reg, 1'b0};
                count_next = CNT_W'(1);
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (cfg_fire) begin
                    state_next = S_INIT;
                end else if (s_fire) begin
                    state_next = S_CHECK;
                    idx_next   = '0;
                    st_next    = ST_OK;
                    ad_next    = '0;
                end
            end
            S_CHECK: begin
                // Entry zero is read here in case the scan goes ahead.
                if (rtype_reg == REQ_ALLOC) begin
                    if (want_reg == '0) begin
                        st_next    = ST_ZERO;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_EVAL;
                    end
                end else if (faddr_reg == '0) begin
                    state_next = S_DONE;
                end else if (faddr_reg < ADDR_W'(base_reg) || faddr_reg >= heap_end) begin
                    st_next    = ST_OUTSIDE;
                    state_next = S_DONE;
                end else begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (rtype_reg == REQ_ALLOC) begin
                    if (rd_used || {1'b0, rd_size} < want_reg) begin
                        if (idx_inc < count_reg) begin
                            idx_next = idx_inc;
                            raddr    = idx_inc[IDX_W-1:0];
                        end else begin
                            st_next    = ST_NOFIT;
                            state_next = S_DONE;
                        end
                    end else if ({1'b0, rd_size} > want_reg) begin
                        // The first fit needs a split; no later block is tried.
                        if (count_reg >= CNT_W'(MAX_BLOCKS)) begin
                            st_next    = ST_FULL;
                            state_next = S_DONE;
                        end else begin
                            cur_off_next  = rd_off;
                            cur_size_next = rd_size;
                            ad_next       = ADDR_W'(base_reg) + ADDR_W'(rd_off);
                            j_next        = count_reg;
                            raddr         = count_dec[IDX_W-1:0];
                            state_next    = (count_reg > idx_inc) ? S_SHW : S_SPLIT;
                        end
                    end else begin
                        we         = 1'b1;
                        wdata      = {rd_off, rd_size, 1'b1};
                        ad_next    = ADDR_W'(base_reg) + ADDR_W'(rd_off);
                        state_next = S_DONE;
                    end
                end else begin
                    if (rd_off != foff_reg) begin
                        if (idx_inc < count_reg) begin
                            idx_next = idx_inc;
                            raddr    = idx_inc[IDX_W-1:0];
                        end else begin
                            st_next    = ST_NOTFOUND;
                            state_next = S_DONE;
                        end
                    end else begin
                        // Mark the block free, even when it already is.
                        cur_off_next   = rd_off;
                        cur_size_next  = rd_size;
                        we             = 1'b1;
                        wdata          = {rd_off, rd_size, 1'b0};
                        pend_prev_next = 1'b1;
                        if (idx_inc < count_reg) begin
                            raddr      = idx_inc[IDX_W-1:0];
                            state_next = S_NXEV;
                        end else if (idx_reg != '0) begin
                            raddr      = idx_dec[IDX_W-1:0];
                            state_next = S_PVEV;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_SHW: begin
                we     = 1'b1;
                waddr  = j_reg[IDX_W-1:0];
                wdata  = rdata;
                j_next = j_dec;
                if (j_dec > idx_inc) begin
                    raddr = j_dec2[IDX_W-1:0];
                end else begin
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT: begin
                we         = 1'b1;
                waddr      = idx_inc[IDX_W-1:0];
                wdata      = {cur_off_reg + OFF_W'(want_reg),
                              cur_size_reg - SIZE_W'(want_reg), 1'b0};
                state_next = S_SETUSED;
            end
            S_SETUSED: begin
                we         = 1'b1;
                wdata      = {cur_off_reg, SIZE_W'(want_reg), 1'b1};
                count_next = count_inc;
                state_next = S_DONE;
            end
            S_NXEV: begin
                if (!rd_used) begin
                    // Absorb the next block, then erase its entry.
                    cur_size_next = sum_size;
                    we            = 1'b1;
                    wdata         = {cur_off_reg, sum_size, 1'b0};
                    j_next        = idx_inc;
                    if (idx_inc2 < count_reg) begin
                        raddr      = idx_inc2[IDX_W-1:0];
                        state_next = S_ERW;
                    end else begin
                        count_next = count_dec;
                        if (idx_reg != '0) begin
                            raddr      = idx_dec[IDX_W-1:0];
                            state_next = S_PVEV;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                end else if (idx_reg != '0) begin
                    raddr      = idx_dec[IDX_W-1:0];
                    state_next = S_PVEV;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_PVEV: begin
                state_next     = S_DONE;
                pend_prev_next = 1'b0;
                if (!rd_used) begin
                    // The previous block absorbs this one; entry idx goes.
                    we     = 1'b1;
                    waddr  = idx_dec[IDX_W-1:0];
                    wdata  = {rd_off, sum_size, 1'b0};
                    j_next = idx_reg;
                    if (idx_inc < count_reg) begin
                        raddr      = idx_inc[IDX_W-1:0];
                        state_next = S_ERW;
                    end else begin
                        count_next = count_dec;
                    end
                end
            end
            S_ERW: begin
                we     = 1'b1;
                waddr  = j_reg[IDX_W-1:0];
                wdata  = rdata;
                j_next = j_inc;
                if (j_inc2 < count_reg) begin
                    raddr = j_inc2[IDX_W-1:0];
                end else begin
                    count_next = count_dec;
                    if (pend_prev_reg && idx_reg != '0) begin
                        raddr      = idx_dec[IDX_W-1:0];
                        state_next = S_PVEV;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE: begin
                // Wait here while an older result is still on the channel.
                if (!mvalid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            base_reg      <= '0;
            bytes_reg     <= HEAP_RESET;
            count_reg     <= CNT_W'(1);
            mvalid_reg    <= 1'b0;
            pend_prev_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_prev_reg <= pend_prev_next;
            if (cfg_fire) begin
                if (cfg_index == CFG_BASE) begin
                    base_reg <= cfg_data;
                end else if (cfg_data[SIZE_W-1:0] > HEAP_LIMIT) begin
                    bytes_reg <= HEAP_LIMIT;
                end else begin
                    bytes_reg <= cfg_data[SIZE_W-1:0];
                end
            end
            if (load_out) begin
                mvalid_reg <= 1'b1;
            end else if (m_ready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        j_reg        <= j_next;
        cur_off_reg  <= cur_off_next;
        cur_size_reg <= cur_size_next;
        st_reg       <= st_next;
        ad_reg       <= ad_next;
        if (s_fire) begin
            rtype_reg <= s_req_type;
            want_reg  <= want_calc;
            faddr_reg <= s_free_address;
            foff_reg  <= s_free_address[OFF_W-1:0] - base_reg[OFF_W-1:0];
        end
        if (load_out) begin
            out_status_reg <= st_reg;
            out_addr_reg   <= (st_reg == ST_OK) ? ad_reg : '0;
        end
    end

    assign m_valid   = mvalid_reg;
    assign m_status  = out_status_reg;
    assign m_address = out_addr_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg >= CNT_W'(1) && count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("entry count out of range");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready)
        else $error("request accepted while busy");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status) && $stable(m_address)))
        else $error("result changed while waiting");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= ST_ZERO))
        else $error("bad status code");

endmodule

`default_nettype wire

// ===== tb/first_fit_heap_allocator_test.sv =====
// ============================================================================
// First-fit heap allocator testbench
// Drives allocate and free requests through several heap settings, predicts
// every status and address with its own copy of the block table, and checks
// each result in order under random idling and one long result hold-off.
// ============================================================================
`default_nettype none

module first_fit_heap_allocator_test;

    import ffha_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam logic [63:0] MASK48 = (64'd1 << 48) - 1;
    localparam logic [63:0] MASK41 = (64'd1 << 41) - 1;
    localparam logic [63:0] MASK49 = (64'd1 << 49) - 1;

    // The scoreboard keeps its own copy of the registers and the block table.
    // Noting a request works out its result at once and queues it; results
    // from the block are then compared against the oldest queued one.
    class alloc_scoreboard;
        logic [63:0] base;
        logic [63:0] bytes;
        logic [63:0] offs[MAX_BLOCKS];
        logic [63:0] sizes[MAX_BLOCKS];
        bit          used[MAX_BLOCKS];
        int          count;
        logic [2:0]           status_q[$];
        logic [ADDR_W-1:0]    address_q[$];
        int          errors;

        function new();
            base   = 0;
            bytes  = 64'd17179869184;
            errors = 0;
            clear_table();
        endfunction

        function void clear_table();
            for (int k = 0; k < MAX_BLOCKS; k++) begin
                offs[k]  = 0;
                sizes[k] = 0;
                used[k]  = 0;
            end
            sizes[0] = bytes;
            count    = 1;
        endfunction

        function void write_reg(logic idx, logic [63:0] data);
            if (idx == CFG_BASE) begin
                base = data & MASK48;
            end else begin
                bytes = data & MASK41;
                if (bytes > (64'd1 << 40)) bytes = 64'd1 << 40;
            end
            clear_table();
        endfunction

        function void erase(int k);
            for (int j = k; j + 1 < count; j++) begin
                offs[j]  = offs[j+1];
                sizes[j] = sizes[j+1];
                used[j]  = used[j+1];
            end
            count--;
            offs[count]  = 0;
            sizes[count] = 0;
            used[count]  = 0;
        endfunction

        // Predict one accepted request, update the table and queue the result.
        function void note_request(logic rtype, logic [SIZE_W-1:0] nbytes,
                                   logic [ADDR_W-1:0] faddr,
                                   output logic [2:0] st, output logic [ADDR_W-1:0] ad);
            logic [63:0] want;
            logic [63:0] off;
            bit          done;
            st   = ST_NOFIT;
            ad   = '0;
            done = 0;
            if (rtype == REQ_ALLOC) begin
                if (nbytes == 0) begin
                    st = ST_ZERO;
                end else begin
                    want = (64'(nbytes) + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
                    for (int i = 0; i < count && !done; i++) begin
                        if (!used[i] && sizes[i] >= want) begin
                            done = 1;
                            if (sizes[i] > want && count >= MAX_BLOCKS) begin
                                st = ST_FULL;
                            end else begin
                                if (sizes[i] > want) begin
                                    for (int j = count; j > i + 1; j--) begin
                                        offs[j]  = offs[j-1];
                                        sizes[j] = sizes[j-1];
                                        used[j]  = used[j-1];
                                    end
                                    offs[i+1]  = offs[i] + want;
                                    sizes[i+1] = sizes[i] - want;
                                    used[i+1]  = 0;
                                    sizes[i]   = want;
                                    count++;
                                end
                                used[i] = 1;
                                st = ST_OK;
                                ad = ADDR_W'((base + offs[i]) & MASK49);
                            end
                        end
                    end
                end
            end else if (faddr == 0) begin
                st = ST_OK;
            end else if (64'(faddr) < base || 64'(faddr) >= base + bytes) begin
                st = ST_OUTSIDE;
            end else begin
                off = 64'(faddr) - base;
                st  = ST_NOTFOUND;
                for (int i = 0; i < count && !done; i++) begin
                    if (offs[i] == off) begin
                        done    = 1;
                        st      = ST_OK;
                        used[i] = 0;
                        if (i + 1 < count && !used[i+1]) begin
                            sizes[i] += sizes[i+1];
                            erase(i + 1);
                        end
                        if (i > 0 && !used[i-1]) begin
                            sizes[i-1] += sizes[i];
                            erase(i);
                        end
                    end
                end
            end
            status_q.insert(status_q.size(), st);
            address_q.insert(address_q.size(), ad);
        endfunction

        function void check_result(logic [2:0] st, logic [ADDR_W-1:0] ad);
            logic [2:0]        est;
            logic [ADDR_W-1:0] ead;
            if (status_q.size() == 0) begin
                $error("result with no request waiting: status %0d address %h", st, ad);
                errors++;
            end else begin
                est = status_q.pop_front();
                ead = address_q.pop_front();
                if (st !== est) begin
                    $error("status: expected %0d, actual %0d", est, st);
                    errors++;
                end
                if (ad !== ead) begin
                    $error("address: expected %h, actual %h", ead, ad);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return status_q.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_req_type;
    logic [SIZE_W-1:0]    s_alloc_bytes;
    logic [ADDR_W-1:0]    s_free_address;
    logic                 m_valid;
    logic                 m_ready;
    logic [2:0]           m_status;
    logic [ADDR_W-1:0]    m_address;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_index;
    logic [BASE_W-1:0]    cfg_data;

    first_fit_heap_allocator dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_alloc_bytes  (s_alloc_bytes),
        .s_free_address (s_free_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_address      (m_address),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    alloc_scoreboard  heap_sb = new();

    // Idle percentages for the two sides. The stimulus only asks for the
    // hold-off; the receiver counts it down itself.
    int unsigned      send_idle_pct = 32;
    int unsigned      recv_idle_pct = 45;
    bit               hold_go       = 1'b0;
    bit               hold_taken    = 1'b0;
    int               hold_cycles   = 0;
    int               quiet_cycles  = 0;

    // Addresses currently handed out, so that frees can target real blocks.
    logic [ADDR_W-1:0] live_addrs[$];

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Results are checked at the edge where they are taken. The receiver
    // then decides its ready for the next cycle, honoring the hold-off.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) heap_sb.check_result(m_status, m_address);
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_go && !hold_taken) begin
            hold_taken  <= 1'b1;
            hold_cycles <= HOLD_CYCLES - 1;
            m_ready     <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready     <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // The watchdog counts cycles in which no request, result or register
    // write moves, and gives up once that stretch grows too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("first_fit_heap_allocator_test: done, errors");
            $finish;
        end
    end

    // Offer one request. Valid from the previous request stays high when no
    // gap is taken, so each edge carries a single assignment to it.
    task automatic send_request(logic rtype, logic [SIZE_W-1:0] nbytes,
                                logic [ADDR_W-1:0] faddr);
        logic [2:0]        st;
        logic [ADDR_W-1:0] ad;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= rtype;
        s_alloc_bytes  <= nbytes;
        s_free_address <= faddr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        heap_sb.note_request(rtype, nbytes, faddr, st, ad);
        if (rtype == REQ_ALLOC && st == ST_OK) live_addrs.insert(live_addrs.size(), ad);
    endtask

    // Wait until every result is in, then let the block settle before
    // its registers are touched.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (heap_sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // A register write clears the table, so the testbench forgets its
    // handed-out addresses along with it.
    task automatic write_reg(logic idx, logic [63:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[BASE_W-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        heap_sb.write_reg(idx, data);
        live_addrs.delete();
    endtask

    // Mostly well-formed traffic: allocations of modest size and frees of
    // blocks that are really held, with some double frees, stray addresses,
    // zero sizes and huge sizes mixed in.
    task automatic run_random(int n, int unsigned alloc_pct, int unsigned max_size);
        int unsigned       r;
        int                k;
        logic [SIZE_W-1:0] nbytes;
        logic [ADDR_W-1:0] faddr;
        for (int it = 0; it < n; it++) begin
            r      = $urandom_range(99);
            nbytes = SIZE_W'({$urandom, $urandom});
            faddr  = ADDR_W'({$urandom, $urandom});
            if (r < alloc_pct) begin
                r = $urandom_range(99);
                if (r < 88) nbytes = SIZE_W'($urandom_range(max_size, 1));
                else if (r < 94) nbytes = '0;
                send_request(REQ_ALLOC, nbytes, faddr);
            end else begin
                r = $urandom_range(99);
                if (live_addrs.size() != 0 && r < 75) begin
                    k     = $urandom_range(live_addrs.size() - 1);
                    faddr = live_addrs[k];
                    // Now and then the address is kept for a later double free.
                    if ($urandom_range(9) != 0) live_addrs.delete(k);
                end else if (r < 82) begin
                    faddr = '0;
                end else if (r < 92) begin
                    faddr = ADDR_W'(heap_sb.base + 64'($urandom_range(4095)));
                end else if (r < 96) begin
                    faddr = ADDR_W'(heap_sb.base - 1);
                end
                send_request(REQ_FREE, nbytes, faddr);
            end
        end
    endtask

    initial begin
        logic [ADDR_W-1:0] a0;
        logic [ADDR_W-1:0] a1;
        logic [ADDR_W-1:0] a2;
        s_valid        = 1'b0;
        s_req_type     = REQ_ALLOC;
        s_alloc_bytes  = '0;
        s_free_address = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_BASE;
        cfg_data       = '0;
        aresetn        = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part on the reset heap: zero size, a huge size that cannot
        // fit, splits, null free, outside and not-found frees, a double free
        // and merges with both neighbours.
        send_request(REQ_ALLOC, '0, '0);
        send_request(REQ_ALLOC, '1, '1);
        send_request(REQ_ALLOC, SIZE_W'(1), '0);
        send_request(REQ_ALLOC, SIZE_W'(257), '0);
        send_request(REQ_ALLOC, SIZE_W'(256), '0);
        a0 = live_addrs[0];
        a1 = live_addrs[1];
        a2 = live_addrs[2];
        send_request(REQ_FREE, '0, '0);
        send_request(REQ_FREE, '0, '1);
        send_request(REQ_FREE, '0, ADDR_W'(64'd17179869184));
        send_request(REQ_FREE, '0, ADDR_W'(128));
        send_request(REQ_FREE, '1, a1);
        send_request(REQ_FREE, '0, a1);
        send_request(REQ_FREE, '0, a0);
        send_request(REQ_FREE, '0, a2);
        live_addrs.delete();

        // The whole heap in one piece, after a write that saturates.
        write_reg(CFG_BASE, 64'hFFFF_0000_0000_1000);
        write_reg(CFG_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(REQ_ALLOC, SIZE_W'(64'd1 << 40), '0);
        send_request(REQ_ALLOC, SIZE_W'(1), '0);
        send_request(REQ_FREE, '0, ADDR_W'(64'h1000 + (64'd1 << 40)));
        send_request(REQ_FREE, '0, ADDR_W'(64'hFFF));
        send_request(REQ_FREE, '0, ADDR_W'(64'h1000));
        live_addrs.delete();

        // The receiver holds off for a long stretch while requests keep
        // coming, so the block backs up and stalls its request channel.
        hold_go = 1'b1;
        run_random(90, 60, 2048);

        // Highest base with an unaligned, short heap.
        write_reg(CFG_BASE, 64'h5A5A_FFFF_FFFF_FF00);
        write_reg(CFG_BYTES, 64'd1000);
        send_request(REQ_ALLOC, SIZE_W'(768), '0);
        send_request(REQ_ALLOC, SIZE_W'(200), '0);
        send_request(REQ_ALLOC, SIZE_W'(300), '0);
        send_request(REQ_ALLOC, SIZE_W'(1), '0);
        send_idle_pct = 45;
        recv_idle_pct = 32;
        run_random(40, 55, 600);

        // Smallest heap with a random aligned base.
        write_reg(CFG_BASE, {$urandom, $urandom} & 64'h0000_FFFF_FFFF_FF00);
        write_reg(CFG_BYTES, 64'd256);
        run_random(40, 60, 300);

        // A small heap that allocation-heavy traffic drives into a full table.
        write_reg(CFG_BYTES, 64'd65536);
        run_random(130, 80, 700);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_BASE, 64'd0);
        write_reg(CFG_BYTES, 64'd1 << 24);
        run_random(150, 65, 4096);

        wait_idle();
        if (heap_sb.errors == 0 && heap_sb.pending() == 0) begin
            $display("first_fit_heap_allocator_test: done, clean");
        end else begin
            $display("first_fit_heap_allocator_test: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/ffha_pkg.sv
hdl/ffha_ram.sv
hdl/first_fit_heap_allocator.sv
tb/first_fit_heap_allocator_test.sv
